FILE: design/dots_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dots_pkg: shared types and constants of the dual order task sorter
// Table depth, entry layout, result kinds and the per-cell control bundle.
// ----------------------------------------------------------------------------
package dots_pkg;

   localparam int DEPTH = 16;
   localparam int CNT_W = $clog2(DEPTH + 1);

   // request action codes
   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_LIST   = 1'b1;

   // result kind codes
   localparam logic [1:0] KIND_INS_OK   = 2'd0;
   localparam logic [1:0] KIND_INS_FULL = 2'd1;
   localparam logic [1:0] KIND_ENTRY    = 2'd2;
   localparam logic [1:0] KIND_EMPTY    = 2'd3;

   // table select codes
   localparam logic SEL_PRIO = 1'b0;
   localparam logic SEL_TIME = 1'b1;

   typedef struct packed {
      logic [7:0]  task_id;
      logic [15:0] exec_time;
      logic [7:0]  prio;
   } entry_type;

   // per-cycle command to every cell of one chain
   typedef struct packed {
      logic ins;   // insert the new entry at its sorted place
      logic rot;   // rotate the occupied cells one place toward the head
   } cell_ctrl_type;

endpackage : dots_pkg
`default_nettype wire

FILE: design/dots_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dots_cell: one slot of a sorted chain
// Holds one entry, compares it with the incoming key and shifts or rotates.
// ----------------------------------------------------------------------------
module dots_cell (
   input  wire                          clock,
   input  dots_pkg::cell_ctrl_type      ctrl,
   input  wire                          by_time,
   input  wire                          is_empty,
   input  wire                          is_tail,
   input  dots_pkg::entry_type          new_entry,
   input  dots_pkg::entry_type          prev_entry,
   input  wire                          prev_cond,
   input  dots_pkg::entry_type          next_entry,
   input  dots_pkg::entry_type          wrap_entry,
   output dots_pkg::entry_type          entry,
   output logic                         cond
);

   dots_pkg::entry_type entry_ff;
   dots_pkg::entry_type entry_in;

   // true where the new entry belongs at or before this slot
   always_comb begin
      if (by_time) begin
         cond = is_empty | (entry_ff.exec_time > new_entry.exec_time);
      end else begin
         cond = is_empty | (entry_ff.prio < new_entry.prio);
      end
   end

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.rot) begin
         entry_in = is_tail ? wrap_entry : next_entry;
      end else if (ctrl.ins && cond) begin
         entry_in = prev_cond ? prev_entry : new_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule : dots_cell
`default_nettype wire

FILE: design/dots_chain.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dots_chain: row of cells forming one sorted table
// Inserts by parallel compare and shift; lists by rotation.
// ----------------------------------------------------------------------------
module dots_chain (
   input  wire                              clock,
   input  dots_pkg::cell_ctrl_type          ctrl,
   input  wire                              by_time,
   input  wire [dots_pkg::CNT_W-1:0]        count,
   input  dots_pkg::entry_type              new_entry,
   output dots_pkg::entry_type              head
);

   dots_pkg::entry_type cell_q [dots_pkg::DEPTH];
   logic                cond_q [dots_pkg::DEPTH];

   for (genvar i = 0; i < dots_pkg::DEPTH; i++) begin : g_cell
      dots_pkg::entry_type prev_e;
      dots_pkg::entry_type next_e;
      logic                prev_c;

      if (i == 0) begin : g_first
         assign prev_e = new_entry;
         assign prev_c = 1'b0;
      end else begin : g_rest
         assign prev_e = cell_q[i-1];
         assign prev_c = cond_q[i-1];
      end

      if (i == dots_pkg::DEPTH - 1) begin : g_lastc
         assign next_e = cell_q[0];
      end else begin : g_midc
         assign next_e = cell_q[i+1];
      end

      dots_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .by_time    (by_time),
         .is_empty   (dots_pkg::CNT_W'(i) >= count),
         .is_tail    (dots_pkg::CNT_W'(i + 1) == count),
         .new_entry  (new_entry),
         .prev_entry (prev_e),
         .prev_cond  (prev_c),
         .next_entry (next_e),
         .wrap_entry (cell_q[0]),
         .entry      (cell_q[i]),
         .cond       (cond_q[i])
      );
   end

   assign head = cell_q[0];

endmodule : dots_chain
`default_nettype wire

FILE: design/dual_order_task_sorter_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dual_order_task_sorter_top: task table kept in priority and time order
// Two chains of cells hold the same tasks, sorted two ways.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: tuser = action (insert or list); tdata = priority_req [7:0],
//   exec_time [23:8], task_id [31:24].
//   rsp channel: tuser = kind [1:0], list_sel [2]; tdata = out_priority [7:0],
//   out_exec_time [23:8], out_task_id [31:24]; tlast marks the final result.
//   Insert: both chains compare and shift in the accept cycle; the status
//   transfer is offered in the cycle after accept. A full table drops the task
//   and answers with the rejected kind.
//   List: the priority chain, then the time chain, rotates toward its head,
//   one entry per cycle while the receiver keeps up, 2 * count transfers;
//   the first is offered once the listing state and then the result register
//   have loaded. After count rotations each chain is back in order.
//   One item is worked at a time: req_tready is high only when no listing is
//   running and the result register is free or being drained.
//   A receiver stall holds the result register and freezes the listing.
//   Reset empties the table (count = 0) and drops any pending result.
// ----------------------------------------------------------------------------
module dual_order_task_sorter_top (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire [31:0]  req_tdata,   // priority_req[7:0], exec_time[23:8], task_id[31:24]
   input  wire         req_tuser,   // action
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata,   // out_priority[7:0], out_exec_time[23:8], out_task_id[31:24]
   output logic [2:0]  rsp_tuser,   // kind[1:0], list_sel[2]
   output logic        rsp_tlast
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_LIST_P = 2'd1;
   localparam logic [1:0] ST_LIST_T = 2'd2;

   logic [1:0]                 state_ff, state_in;
   logic [dots_pkg::CNT_W-1:0] count_ff, count_in;
   logic [dots_pkg::CNT_W-1:0] idx_ff, idx_in;

   logic                rsp_valid_ff, rsp_valid_in;
   dots_pkg::entry_type rsp_entry_ff, rsp_entry_in;
   logic [1:0]          rsp_kind_ff, rsp_kind_in;
   logic                rsp_sel_ff, rsp_sel_in;
   logic                rsp_last_ff, rsp_last_in;

   dots_pkg::entry_type     new_entry;
   dots_pkg::entry_type     head_p, head_t;
   dots_pkg::cell_ctrl_type ctrl_p, ctrl_t;

   logic out_free;
   logic accept;
   logic full;
   logic at_end;

   assign new_entry = dots_pkg::entry_type'(req_tdata);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_tvalid && req_tready;
   assign full      = (count_ff == dots_pkg::CNT_W'(dots_pkg::DEPTH));
   assign at_end    = (idx_ff == count_ff - dots_pkg::CNT_W'(1));

   dots_chain u_chain_prio (
      .clock     (clock),
      .ctrl      (ctrl_p),
      .by_time   (1'b0),
      .count     (count_ff),
      .new_entry (new_entry),
      .head      (head_p)
   );

   dots_chain u_chain_time (
      .clock     (clock),
      .ctrl      (ctrl_t),
      .by_time   (1'b1),
      .count     (count_ff),
      .new_entry (new_entry),
      .head      (head_t)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      rsp_entry_in = rsp_entry_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_sel_in   = rsp_sel_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      ctrl_p       = '0;
      ctrl_t       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser == dots_pkg::ACT_INSERT) begin
                  // status transfer; store the task unless the table is full
                  rsp_valid_in = 1'b1;
                  rsp_entry_in = '0;
                  rsp_sel_in   = dots_pkg::SEL_PRIO;
                  rsp_last_in  = 1'b1;
                  if (full) begin
                     rsp_kind_in = dots_pkg::KIND_INS_FULL;
                  end else begin
                     rsp_kind_in = dots_pkg::KIND_INS_OK;
                     ctrl_p.ins  = 1'b1;
                     ctrl_t.ins  = 1'b1;
                     count_in    = count_ff + dots_pkg::CNT_W'(1);
                  end
               end else if (count_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_entry_in = '0;
                  rsp_sel_in   = dots_pkg::SEL_PRIO;
                  rsp_kind_in  = dots_pkg::KIND_EMPTY;
                  rsp_last_in  = 1'b1;
               end else begin
                  state_in = ST_LIST_P;
                  idx_in   = '0;
               end
            end
         end
         ST_LIST_P: begin
            if (out_free) begin
               // emit the head, then rotate the chain to bring up the next one
               rsp_valid_in = 1'b1;
               rsp_entry_in = head_p;
               rsp_sel_in   = dots_pkg::SEL_PRIO;
               rsp_kind_in  = dots_pkg::KIND_ENTRY;
               rsp_last_in  = 1'b0;
               ctrl_p.rot   = 1'b1;
               if (at_end) begin
                  state_in = ST_LIST_T;
                  idx_in   = '0;
               end else begin
                  idx_in = idx_ff + dots_pkg::CNT_W'(1);
               end
            end
         end
         ST_LIST_T: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_entry_in = head_t;
               rsp_sel_in   = dots_pkg::SEL_TIME;
               rsp_kind_in  = dots_pkg::KIND_ENTRY;
               rsp_last_in  = at_end;
               ctrl_t.rot   = 1'b1;
               if (at_end) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + dots_pkg::CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload; needs no reset
   always_ff @(posedge clock) begin
      rsp_entry_ff <= rsp_entry_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_sel_ff   <= rsp_sel_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = 32'(rsp_entry_ff);
   assign rsp_tuser  = {rsp_sel_ff, rsp_kind_ff};
   assign rsp_tlast  = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= dots_pkg::CNT_W'(dots_pkg::DEPTH))
      else $error("entry count above table depth");

   a_list_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (count_ff != '0) && (idx_ff < count_ff))
      else $error("listing with empty table or index past count");

   a_insert_counts: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser == dots_pkg::ACT_INSERT && !full)
      |=> (count_ff == $past(count_ff) + dots_pkg::CNT_W'(1)))
      else $error("accepted insert did not grow the table");

   a_last_entry_time: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == dots_pkg::KIND_ENTRY && rsp_last_ff)
      |-> (rsp_sel_ff == dots_pkg::SEL_TIME))
      else $error("final listing entry not from the time table");

   a_count_stable_list: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |=> $stable(count_ff))
      else $error("table count changed during a listing");

endmodule : dual_order_task_sorter_top
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for dual_order_task_sorter_top
// Drives inserts and listings over the req stream, predicts the status and
// listing transfers from a local copy of both sorted tables, and checks every
// rsp transfer field by field, with random idle on both sides in some phases.
// ----------------------------------------------------------------------------
module testbench;

   // give up after this many cycles in which no transfer happens on any side
   localparam int WATCHDOG_LIMIT = 5000;
   // cycles to wait after the last expected result before the verdict
   localparam int SETTLE_CYCLES = 40;

   // one expected result transfer, split into its fields
   typedef struct packed {
      logic [1:0]          kind;
      logic                list_sel;
      dots_pkg::entry_type ent;
      logic                last;
   } sorter_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;    // priority_req[7:0], exec_time[23:8], task_id[31:24]
   logic        req_tuser = 1'b0;  // action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // out_priority[7:0], out_exec_time[23:8], out_task_id[31:24]
   logic [2:0]  rsp_tuser;         // kind[1:0], list_sel[2]
   logic        rsp_tlast;

   // idle rates in percent of cycles, changed per test phase
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // local copy of the block state: both orderings and the fill level
   dots_pkg::entry_type prio_order [dots_pkg::DEPTH];
   dots_pkg::entry_type time_order [dots_pkg::DEPTH];
   int                  held_count = 0;

   sorter_rsp_type pending_results [$];
   int             mismatches = 0;
   int             quiet_cycles = 0;

   dual_order_task_sorter_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------
   function automatic void queue_result(logic [1:0] kind, logic sel,
                                        dots_pkg::entry_type ent, logic last);
      sorter_rsp_type r;
      r.kind     = kind;
      r.list_sel = sel;
      r.ent      = ent;
      r.last     = last;
      pending_results.push_back(r);
   endfunction

   // Update the local tables for one accepted request and queue its results.
   function automatic void predict_sorter(logic act, dots_pkg::entry_type e);
      int ppos;
      int tpos;
      if (act == dots_pkg::ACT_INSERT) begin
         if (held_count >= dots_pkg::DEPTH) begin
            queue_result(dots_pkg::KIND_INS_FULL, dots_pkg::SEL_PRIO, '0, 1'b1);
            return;
         end
         // new task goes behind every stored task with an equal key
         ppos = 0;
         while (ppos < held_count && prio_order[ppos].prio >= e.prio) ppos++;
         tpos = 0;
         while (tpos < held_count && time_order[tpos].exec_time <= e.exec_time) tpos++;
         for (int k = held_count; k > ppos; k--) prio_order[k] = prio_order[k - 1];
         for (int k = held_count; k > tpos; k--) time_order[k] = time_order[k - 1];
         prio_order[ppos] = e;
         time_order[tpos] = e;
         held_count++;
         queue_result(dots_pkg::KIND_INS_OK, dots_pkg::SEL_PRIO, '0, 1'b1);
      end else if (held_count == 0) begin
         queue_result(dots_pkg::KIND_EMPTY, dots_pkg::SEL_PRIO, '0, 1'b1);
      end else begin
         for (int i = 0; i < held_count; i++)
            queue_result(dots_pkg::KIND_ENTRY, dots_pkg::SEL_PRIO, prio_order[i], 1'b0);
         for (int i = 0; i < held_count; i++)
            queue_result(dots_pkg::KIND_ENTRY, dots_pkg::SEL_TIME, time_order[i],
                         i == held_count - 1);
      end
   endfunction

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------
   function automatic dots_pkg::entry_type task_entry(logic [7:0] prio,
                                                      logic [15:0] exec_time,
                                                      logic [7:0] task_id);
      dots_pkg::entry_type e;
      e.prio      = prio;
      e.exec_time = exec_time;
      e.task_id   = task_id;
      return e;
   endfunction

   // Half of the keys come from a few corner values so that ties are common.
   function automatic dots_pkg::entry_type random_entry();
      dots_pkg::entry_type e;
      e.prio      = $urandom_range(1) ? 8'($urandom_range(3) * 85) : 8'($urandom_range(255));
      e.exec_time = $urandom_range(1) ? 16'($urandom_range(3) * 21845)
                                      : 16'($urandom_range(65535));
      e.task_id   = 8'($urandom_range(255));
      return e;
   endfunction

   // Offer one request, hold it until the transfer, then predict its results.
   // Handshake is sampled at the falling edge, where both sides are stable.
   task automatic send_request(input logic act, input dots_pkg::entry_type e);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= e;
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      predict_sorter(act, e);
   endtask

   // Drop valid and hold off until every predicted result has been seen.
   task automatic hold_until_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Result side: random stall, field-by-field check, watchdog
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_tready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(negedge clock) begin
      sorter_rsp_type      want;
      dots_pkg::entry_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_results.size() == 0) begin
            $display("%0t ns: result with none expected, actual tuser %0h tdata %0h last %0b",
                     $time, rsp_tuser, rsp_tdata, rsp_tlast);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            compare_field("kind", want.kind, rsp_tuser[1:0]);
            compare_field("list_sel", want.list_sel, rsp_tuser[2]);
            compare_field("out_priority", want.ent.prio, got.prio);
            compare_field("out_exec_time", want.ent.exec_time, got.exec_time);
            compare_field("out_task_id", want.ent.task_id, got.task_id);
            compare_field("last", want.last, rsp_tlast);
         end
      end
   end

   // count cycles without any transfer; a stuck block ends the run here
   always @(negedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: watchdog, no transfer for %0d cycles", $time, quiet_cycles);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Listing right after reset: a single empty marker.
   task automatic test_empty_listing();
      send_request(dots_pkg::ACT_LIST, random_entry());
   endtask

   // Key extremes, id extremes and ties on both keys, then list.
   task automatic test_extremes_and_ties();
      send_request(dots_pkg::ACT_INSERT, task_entry(8'd255, 16'hFFFF, 8'd0));
      send_request(dots_pkg::ACT_INSERT, task_entry(8'd0,   16'h0000, 8'd255));
      // ties the first on priority and the second on time, then the reverse
      send_request(dots_pkg::ACT_INSERT, task_entry(8'd255, 16'h0000, 8'd1));
      send_request(dots_pkg::ACT_INSERT, task_entry(8'd0,   16'hFFFF, 8'd2));
      // equal on both keys, must keep arrival order in both tables
      send_request(dots_pkg::ACT_INSERT, task_entry(8'd128, 16'h8000, 8'hAA));
      send_request(dots_pkg::ACT_INSERT, task_entry(8'd128, 16'h8000, 8'h55));
      send_request(dots_pkg::ACT_LIST, task_entry(8'hFF, 16'hFFFF, 8'hFF));
   endtask

   // Random mix of inserts and listings under the given idle rates.
   task automatic test_random_mix(int n_items, int s_pct, int r_pct);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      repeat (n_items)
         send_request(($urandom_range(99) < 30) ? dots_pkg::ACT_INSERT : dots_pkg::ACT_LIST,
                      random_entry());
   endtask

   // Fill to capacity, show that further inserts are dropped, list the full table.
   task automatic test_full_table();
      while (held_count < dots_pkg::DEPTH) send_request(dots_pkg::ACT_INSERT, random_entry());
      send_request(dots_pkg::ACT_INSERT, task_entry(8'd255, 16'h0000, 8'd255));
      send_request(dots_pkg::ACT_INSERT, task_entry(8'd0, 16'hFFFF, 8'd0));
      send_request(dots_pkg::ACT_LIST, random_entry());
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_empty_listing();
      test_extremes_and_ties();
      // pause the sender until the listing has fully drained
      hold_until_drained();
      test_random_mix(50, 16, 88);
      hold_until_drained();
      test_random_mix(50, 88, 16);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_full_table();
      test_random_mix(50, 0, 0);

      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: files.f
design/dots_pkg.sv
design/dots_cell.sv
design/dots_chain.sv
design/dual_order_task_sorter_top.sv
tb/testbench.sv
